// File: rtl/core/oven_stability_supervisor_macros.svh
// Assertion macros for the oven stability supervisor checker.
// Depends on nothing; included by the assertion checker only.
`ifndef OVEN_STABILITY_SUPERVISOR_MACROS_SVH
`define OVEN_STABILITY_SUPERVISOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OSV_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("osv assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define OSV_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("osv assertion failed");

`endif

// File: rtl/core/osv_pkg.sv
// Shared types, codes and constants for the oven stability supervisor.
// No dependencies; compiled before every other file of the block.
package osv_pkg;

    // Field widths
    localparam int TEMP_W   = 14;
    localparam int CNT_W    = 10;
    localparam int TIME_W   = 32;
    localparam int POWER_W  = 16;
    localparam int MARGIN_W = 13;
    localparam int BAND_W   = 7;
    localparam int MODE_W   = 3;
    localparam int DRIVE_W  = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    // Output mode codes
    localparam logic [MODE_W-1:0] MODE_CODE_OFF        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_PREHEAT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_TRANSITION = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_AWAITING   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_STEADY     = 3'd4;

    // Register reset values
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 13'd200;
    localparam logic [BAND_W-1:0]   BAND_RST   = 7'd5;

    // Supervisor mode, one-hot
    typedef enum logic [4:0] {
        ST_OFF        = 5'b00001,
        ST_PREHEAT    = 5'b00010,
        ST_TRANSITION = 5'b00100,
        ST_AWAITING   = 5'b01000,
        ST_STEADY     = 5'b10000
    } mode_state_t;

    typedef enum logic [DRIVE_W-1:0] {
        DRIVE_ZERO    = 2'd0,
        DRIVE_PREHEAT = 2'd1,
        DRIVE_PID     = 2'd2,
        DRIVE_KEEP    = 2'd3
    } drive_t;

    // Register index (word address)
    typedef enum logic [1:0] {
        REG_SETTLE = 2'd0,
        REG_POWER  = 2'd1,
        REG_MARGIN = 2'd2,
        REG_BAND   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]   settle_time_ms;
        logic [POWER_W-1:0]  preheat_power;
        logic [MARGIN_W-1:0] preheat_margin;
        logic [BAND_W-1:0]   stable_band;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [TEMP_W-1:0] temperature;
        logic [TEMP_W-1:0] target;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        drive_t             drive;
        logic [POWER_W-1:0] power;
        logic [CNT_W-1:0]   band_count;
    } res_t;

    typedef struct packed {
        mode_state_t       mode;
        logic [TEMP_W-1:0] target;
        logic [TEMP_W-1:0] last_temp;
        logic [CNT_W-1:0]  count;
        logic              started;
        logic [TIME_W-1:0] start_time;
    } sv_state_t;

    // One-hot mode to reported code
    function automatic logic [MODE_W-1:0] mode_code(mode_state_t s);
        logic [MODE_W-1:0] c;
        case (s)
            ST_OFF:        c = MODE_CODE_OFF;
            ST_PREHEAT:    c = MODE_CODE_PREHEAT;
            ST_TRANSITION: c = MODE_CODE_TRANSITION;
            ST_AWAITING:   c = MODE_CODE_AWAITING;
            ST_STEADY:     c = MODE_CODE_STEADY;
            default:       c = MODE_CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/osv_if.sv
// Valid/ready channel interfaces for the supervisor's input and result words.
// Depends on osv_pkg for the field widths.
interface osv_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [osv_pkg::TEMP_W-1:0] temperature;
    logic [osv_pkg::TEMP_W-1:0] target;
    logic [osv_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, kind, temperature, target, now_ms, input ready);
    modport sink   (input valid, kind, temperature, target, now_ms, output ready);
endinterface

interface osv_out_if;
    logic                        valid;
    logic                        ready;
    logic [osv_pkg::MODE_W-1:0]  mode;
    logic [osv_pkg::DRIVE_W-1:0] drive;
    logic [osv_pkg::POWER_W-1:0] power;
    logic [osv_pkg::CNT_W-1:0]   band_count;

    modport source (output valid, mode, drive, power, band_count, input ready);
    modport sink   (input valid, mode, drive, power, band_count, output ready);
endinterface

// File: rtl/core/osv_cfg.sv
// APB-style configuration registers of the supervisor.
// Depends on osv_pkg for the register map and the cfg_t bundle.
module osv_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [osv_pkg::APB_AW-1:0] paddr,
    input  logic [osv_pkg::APB_DW-1:0] pwdata,
    output logic [osv_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output osv_pkg::cfg_t              cfg
);
    import osv_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_time_ms <= '0;
            cfg_reg.preheat_power  <= '0;
            cfg_reg.preheat_margin <= MARGIN_RST;
            cfg_reg.stable_band    <= BAND_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SETTLE: cfg_reg.settle_time_ms <= pwdata;
                REG_POWER:  cfg_reg.preheat_power  <= pwdata[POWER_W-1:0];
                REG_MARGIN: cfg_reg.preheat_margin <= pwdata[MARGIN_W-1:0];
                REG_BAND:   cfg_reg.stable_band    <= pwdata[BAND_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        case (idx)
            REG_SETTLE: prdata = cfg_reg.settle_time_ms;
            REG_POWER:  prdata = {{(APB_DW-POWER_W){1'b0}}, cfg_reg.preheat_power};
            REG_MARGIN: prdata = {{(APB_DW-MARGIN_W){1'b0}}, cfg_reg.preheat_margin};
            REG_BAND:   prdata = {{(APB_DW-BAND_W){1'b0}}, cfg_reg.stable_band};
            default:    prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/osv_step.sv
// Next-state and result logic for one supervisor word (sample or new target).
// Depends on osv_pkg for state, item, result and configuration types.
module osv_step
#(
    parameter int COUNT_MAX = 600,
    parameter int COUNT_ARM = 590
)
(
    input  osv_pkg::cfg_t      cfg,
    input  osv_pkg::in_item_t  item,
    input  osv_pkg::sv_state_t st,
    output osv_pkg::sv_state_t st_next,
    output osv_pkg::res_t      res
);
    import osv_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);
    localparam logic [CNT_W-1:0] CNT_ARM = CNT_W'(COUNT_ARM);

    logic signed [15:0] tgt_s;
    logic signed [15:0] tmp_s;
    logic signed [15:0] last_s;
    logic signed [15:0] new_t_s;
    logic signed [15:0] margin_s;
    logic signed [15:0] band_s;
    logic signed [15:0] below_s;
    logic signed [15:0] rise_s;
    logic signed [15:0] diff_s;
    logic               in_band;
    logic [CNT_W-1:0]   cnt_upd;
    logic [TIME_W-1:0]  time_base;
    logic [TIME_W-1:0]  elapsed;
    drive_t             drive;

    // Sign-extended temperatures; zero-extended margin and band
    assign tgt_s    = {{2{st.target[TEMP_W-1]}}, st.target};
    assign last_s   = {{2{st.last_temp[TEMP_W-1]}}, st.last_temp};
    assign tmp_s    = {{2{item.temperature[TEMP_W-1]}}, item.temperature};
    assign new_t_s  = {{2{item.target[TEMP_W-1]}}, item.target};
    assign margin_s = {3'b000, cfg.preheat_margin};
    assign band_s   = {9'b0, cfg.stable_band};

    assign below_s = tgt_s - tmp_s;
    assign rise_s  = new_t_s - last_s;
    assign diff_s  = tmp_s - tgt_s;
    assign in_band = (diff_s >= -band_s) && (diff_s <= band_s);

    // Saturating in-band counter
    always_comb
    begin
        cnt_upd = st.count;
        if (in_band)
        begin
            if (st.count < CNT_MAX)
                cnt_upd = st.count + 1'b1;
        end
        else if (st.count != '0)
        begin
            cnt_upd = st.count - 1'b1;
        end
    end

    // Settle timer; a fresh start counts from the current time
    assign time_base = st.started ? st.start_time : item.now_ms;
    assign elapsed   = item.now_ms - time_base;

    always_comb
    begin
        st_next = st;
        drive   = DRIVE_KEEP;
        if (item.kind == KIND_TARGET)
        begin
            st_next.target     = item.target;
            st_next.count      = '0;
            st_next.started    = 1'b0;
            st_next.start_time = '0;
            st_next.mode       = ST_TRANSITION;
            if (rise_s >= margin_s)
            begin
                st_next.mode = ST_PREHEAT;
                drive        = DRIVE_PREHEAT;
            end
            if (new_t_s <= 16'sd0)
            begin
                st_next.mode = ST_OFF;
                drive        = DRIVE_ZERO;
            end
        end
        else
        begin
            st_next.last_temp = item.temperature;
            if (st.mode != ST_OFF && below_s >= margin_s)
            begin
                st_next.mode = ST_PREHEAT;
                drive        = DRIVE_PREHEAT;
            end
            else
            begin
                if (st.mode == ST_PREHEAT)
                    st_next.mode = ST_TRANSITION;
                drive         = DRIVE_PID;
                st_next.count = cnt_upd;
                if (cnt_upd >= CNT_ARM)
                begin
                    if (!st.started)
                    begin
                        st_next.started    = 1'b1;
                        st_next.start_time = item.now_ms;
                        st_next.mode       = ST_AWAITING;
                    end
                    if (elapsed >= cfg.settle_time_ms)
                        st_next.mode = ST_STEADY;
                end
            end
        end
    end

    // Result word
    assign res.mode       = mode_code(st_next.mode);
    assign res.drive      = drive;
    assign res.power      = (drive == DRIVE_PREHEAT) ? cfg.preheat_power : '0;
    assign res.band_count = st_next.count;

endmodule

// File: rtl/core/oven_stability_supervisor.sv
// Oven stability supervisor: input register -> step logic -> result register.
// An accepted word waits in the input register until the result slot frees, then its result is registered.
// Throughput: one word per cycle while out_ch.ready does not stall the result; the state update
// sits between the input and result registers, so both stages advance together.
// Reset (rst_n, async, active low) empties both stages, sets mode off,
// clears the counter, timer and temperatures and loads register defaults.
module oven_stability_supervisor
#(
    parameter int COUNT_MAX = 600,
    parameter int COUNT_ARM = 590
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    osv_in_if.sink                     in_ch,
    osv_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [osv_pkg::APB_AW-1:0] paddr,
    input  logic [osv_pkg::APB_DW-1:0] pwdata,
    output logic [osv_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import osv_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_vld_reg;
    res_t      out_res_reg;
    logic      out_vld_reg;
    sv_state_t st_reg;
    sv_state_t st_next;
    res_t      res_next;
    logic      advance;
    logic      in_take;

    osv_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    osv_step #(
        .COUNT_MAX (COUNT_MAX),
        .COUNT_ARM (COUNT_ARM)
    ) u_step
    (
        .cfg     (cfg),
        .item    (in_item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Pipeline control: the input stage moves on when the result slot frees
    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_vld_reg <= in_ch.valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind        <= in_ch.kind;
            in_item_reg.temperature <= in_ch.temperature;
            in_item_reg.target      <= in_ch.target;
            in_item_reg.now_ms      <= in_ch.now_ms;
        end
    end

    // Supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode       <= ST_OFF;
            st_reg.target     <= '0;
            st_reg.last_temp  <= '0;
            st_reg.count      <= '0;
            st_reg.started    <= 1'b0;
            st_reg.start_time <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.mode       = out_res_reg.mode;
    assign out_ch.drive      = out_res_reg.drive;
    assign out_ch.power      = out_res_reg.power;
    assign out_ch.band_count = out_res_reg.band_count;

endmodule

// File: rtl/core/osv_checker.sv
// Port-level assertion checker for the oven stability supervisor, bound to the top.
// Depends on osv_pkg and oven_stability_supervisor_macros.svh.
`include "oven_stability_supervisor_macros.svh"

module osv_checker
#(
    parameter int COUNT_MAX = 600
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [osv_pkg::MODE_W-1:0]  mode,
    input logic [osv_pkg::DRIVE_W-1:0] drive,
    input logic [osv_pkg::POWER_W-1:0] power,
    input logic [osv_pkg::CNT_W-1:0]   band_count
);
    import osv_pkg::*;

    // A stalled result word holds
    `OSV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mode) && $stable(band_count) && $stable(power))

    // Counter never passes its ceiling
    `OSV_ASSERT_IMPLIES(a_cnt_max, clk, rst_n, out_valid, band_count <= COUNT_MAX)

    // Power only shows in preheat drive; zero drive reports mode off with a cleared counter
    `OSV_ASSERT_IMPLIES(a_power, clk, rst_n, out_valid && drive != DRIVE_PREHEAT, power == '0)
    `OSV_ASSERT_IMPLIES(a_drive_zero, clk, rst_n, out_valid && drive == DRIVE_ZERO, mode == MODE_CODE_OFF && band_count == '0)

endmodule

bind oven_stability_supervisor osv_checker #(
    .COUNT_MAX (COUNT_MAX)
) u_osv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .mode       (out_ch.mode),
    .drive      (out_ch.drive),
    .power      (out_ch.power),
    .band_count (out_ch.band_count)
);
